FILE: src/bfa_pkg.sv
// Package for the bitmap first-free allocator.
// Holds request/response payload types, opcodes, FSM states and the bit search helper.
// No dependencies.
`default_nettype none

package bfa_pkg;

   // Opcodes carried in a request
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam int BITS_PER_WORD = 32;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [10:0] word_index;
      logic [31:0] word_value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] bit_index;
      logic [31:0] read_value;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_SUM,
      ST_ALLOC_WORD,
      ST_WRITE_SUM,
      ST_READ_WORD,
      ST_RESP
   } state_type;

   // Position of the lowest clear bit; 0 when the word is all ones
   function automatic logic [4:0] first_zero(input logic [31:0] w);
      logic [4:0] r;
      r = 5'd0;
      for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
         if (!w[i]) begin
            r = 5'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/bfa_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Used for the bitmap words and for the per-word full summary. No dependencies.
`default_nettype none

module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: src/bitmap_first_free_allocator_top.sv
// Bitmap first-free allocator, top level.
// Uses bfa_pkg (types, opcodes, states) and bfa_ram (bitmap and summary memories).
//
// Requests come in on req_valid/req_stall with a req_type payload: allocate,
// write word or read word. Every request yields exactly one response on
// rsp_valid/rsp_stall. csr_valid/csr_ready writes blocks_in_use (resets to 1).
// The bitmap lives in a RAM of WORDS_PER_BLOCK*MAX_BLOCKS words. A second RAM
// keeps one "word is full" bit per bitmap word, 32 words per summary entry, and
// one flip-flop per summary entry marks a group of 32 full words. An allocate
// picks the first non-full group, reads its summary entry, reads the chosen
// word and writes back both. When that word lies past the searched blocks,
// or every group is full, the response has found low. A write does a
// summary read-modify-write, a read fetches the word, and an unused opcode
// or out-of-range word goes straight to the response.
// One request is in flight at a time; a new request is taken as soon as the
// previous result sits in the output register, even while it is stalled.
// A stalled response holds; the next result waits until the register frees.
// After reset the block sweeps both RAMs to zero, one word per cycle, with
// req_stall high, over all WORDS_PER_BLOCK*MAX_BLOCKS words (2048 by default).
// Configuration writes are accepted at any time.
`default_nettype none

module bitmap_first_free_allocator_top
   import bfa_pkg::*;
#(
   parameter int WORDS_PER_BLOCK = 256,
   parameter int MAX_BLOCKS      = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [3:0] csr_data
);

   localparam int DEPTH  = WORDS_PER_BLOCK * MAX_BLOCKS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SDEPTH = (DEPTH + BITS_PER_WORD - 1) / BITS_PER_WORD;
   localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
   localparam int AXW    = SAW + 5;

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [AXW-1:0]   addr_ff, addr_in;
   logic [31:0]      wval_ff, wval_in;
   logic [31:0]      sum_ff, sum_in;
   logic [SDEPTH-1:0] gfull_ff, gfull_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       blocks_ff, blocks_in;

   logic             bm_we, sm_we;
   logic [AW-1:0]    bm_waddr, bm_raddr;
   logic [SAW-1:0]   sm_waddr, sm_raddr;
   logic [31:0]      bm_wdata, bm_rdata, sm_wdata, sm_rdata;

   logic [SAW-1:0]   free_grp;
   logic             any_grp;
   logic [31:0]      limit;
   logic [31:0]      nblk;
   logic             out_free;

   // bitmap words
   bfa_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   // full summary, one bit per bitmap word
   bfa_ram #(.WIDTH(32), .DEPTH(SDEPTH), .AW(SAW)) u_summary (
      .clock   (clock),
      .wr_en   (sm_we),
      .wr_addr (sm_waddr),
      .wr_data (sm_wdata),
      .rd_addr (sm_raddr),
      .rd_data (sm_rdata)
   );

   // first group of 32 words that still has a free word
   always_comb begin
      free_grp = '0;
      any_grp  = 1'b0;
      for (int i = SDEPTH - 1; i >= 0; i--) begin
         if (!gfull_ff[i]) begin
            free_grp = SAW'(i);
            any_grp  = 1'b1;
         end
      end
   end

   // searched word range: saturated block count times block size
   always_comb begin
      nblk  = (32'(blocks_ff) > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS) : 32'(blocks_ff);
      limit = nblk * 32'(WORDS_PER_BLOCK);
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state, datapath and memory control
   always_comb begin
      logic [4:0]     wbit;
      logic [4:0]     bbit;
      logic [AXW-1:0] waddr;
      logic [31:0]    new_word;
      logic [31:0]    new_sum;
      logic [31:0]    gidx;

      state_in     = state_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      wval_in      = wval_ff;
      sum_in       = sum_ff;
      gfull_in     = gfull_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      blocks_in    = (csr_valid && csr_ready) ? csr_data : blocks_ff;

      bm_we    = 1'b0;
      bm_waddr = AW'(addr_ff);
      bm_wdata = '0;
      bm_raddr = AW'(addr_ff);
      sm_we    = 1'b0;
      sm_waddr = addr_ff[AXW-1:5];
      sm_wdata = '0;
      sm_raddr = addr_ff[AXW-1:5];

      wbit     = first_zero(sm_rdata);
      bbit     = first_zero(bm_rdata);
      waddr    = {addr_ff[AXW-1:5], wbit};
      new_word = bm_rdata | (32'd1 << bbit);
      new_sum  = '0;
      gidx     = '0;

      unique case (state_ff)
         // zero both memories after reset
         ST_CLEAR: begin
            bm_we    = 1'b1;
            bm_waddr = clr_ff;
            sm_we    = (32'(clr_ff) < 32'(SDEPTH));
            sm_waddr = SAW'(clr_ff);
            clr_in   = clr_ff + AW'(1);
            if (32'(clr_ff) == 32'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               res_in  = '0;
               wval_in = req_data.word_value;
               addr_in = AXW'(req_data.word_index);
               bm_raddr = AW'(req_data.word_index);
               sm_raddr = SAW'(req_data.word_index >> 5);
               case (req_data.opcode)
                  OP_ALLOC: begin
                     addr_in  = {free_grp, 5'd0};
                     sm_raddr = free_grp;
                     state_in = any_grp ? ST_ALLOC_SUM : ST_RESP;
                  end
                  OP_WRITE: begin
                     state_in = (32'(req_data.word_index) < 32'(DEPTH)) ? ST_WRITE_SUM
                                                                        : ST_RESP;
                  end
                  OP_READ: begin
                     state_in = (32'(req_data.word_index) < 32'(DEPTH)) ? ST_READ_WORD
                                                                        : ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // summary entry ready: pick the word, fetch it
         ST_ALLOC_SUM: begin
            sum_in   = sm_rdata;
            addr_in  = waddr;
            bm_raddr = AW'(waddr);
            state_in = (32'(waddr) < limit) ? ST_ALLOC_WORD : ST_RESP;
         end

         // word ready: claim the bit, write back word and summary
         ST_ALLOC_WORD: begin
            new_sum = sum_ff;
            if (&new_word) begin
               new_sum = sum_ff | (32'd1 << addr_ff[4:0]);
            end
            bm_we    = 1'b1;
            bm_wdata = new_word;
            sm_we    = 1'b1;
            sm_wdata = new_sum;
            gfull_in[addr_ff[AXW-1:5]] = &new_sum;
            gidx = 32'({addr_ff, bbit});
            res_in.found     = 1'b1;
            res_in.bit_index = gidx[15:0];
            state_in = ST_RESP;
         end

         // store the word and refresh its summary bit
         ST_WRITE_SUM: begin
            new_sum = sm_rdata;
            new_sum[addr_ff[4:0]] = &wval_ff;
            bm_we    = 1'b1;
            bm_wdata = wval_ff;
            sm_we    = 1'b1;
            sm_wdata = new_sum;
            gfull_in[addr_ff[AXW-1:5]] = &new_sum;
            state_in = ST_RESP;
         end

         ST_READ_WORD: begin
            res_in.read_value = bm_rdata;
            state_in = ST_RESP;
         end

         // hand the result to the output register once it is free
         ST_RESP: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         gfull_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         blocks_ff    <= 4'd1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         gfull_ff     <= gfull_in;
         rsp_valid_ff <= rsp_valid_in;
         blocks_ff    <= blocks_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      wval_ff <= wval_in;
      sum_ff  <= sum_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire
